/* hw/rtl/huffman_tree_build_code_decode_defines.svh */
// Assertion macros for the Huffman tree block.
// Each expects signals named clock and reset in scope.
`ifndef HUFFMAN_TREE_BUILD_CODE_DECODE_DEFINES_SVH
`define HUFFMAN_TREE_BUILD_CODE_DECODE_DEFINES_SVH

// Same-cycle implication.
`define HUF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define HUF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/huf_pkg.sv */
package huf_pkg;

   localparam int LEAVES_DEF = 16;
   localparam int SYM_W      = 8;
   localparam int WEIGHT_W   = 16;
   localparam int LIDX_W     = 4;
   localparam int CODE_W     = 15;
   localparam int CLEN_W     = 4;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_DECODE = 1'b1;

   localparam logic KIND_CODE   = 1'b0;
   localparam logic KIND_SYMBOL = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SCAN_END,
      ST_SCAN_DONE,
      ST_MERGE_A,
      ST_MERGE_B,
      ST_EMIT_START,
      ST_EMIT_CHK,
      ST_EMIT_WAIT,
      ST_DEC_WAIT,
      ST_DEC_SYM
   } state_type;

   // control into the min-select unit
   typedef struct packed {
      logic clear;   // drop the running best
      logic sample;  // offered node is eligible this cycle
   } minsel_ctl_type;

endpackage

/* hw/rtl/huffman_tree_build_code_decode.sv */
// Channel   Ports                                   Handshake
// --------  --------------------------------------  ----------------------------
// request   req_opcode/symbol/weight/bit/eos        start & !busy -> transfer
// result    rsp_result_kind/out_symbol/leaf_index/   rsp_strobe, one cycle,
//           code_bits/code_length/last               no back-pressure
//
// A load does not raise busy; the LEAVES-th load starts the build and holds busy.
// Build: per merged node two scans over the weight RAM (one read port, one
//   shared min-select unit), then the merge states MERGE_A and MERGE_B.
// Code emit: per leaf, walking the parent RAM upward.
// Decode: each bit passes IDLE and DEC_WAIT, then DEC_SYM when a leaf is reached.
// Reset is synchronous; node stores hold junk until the first build.
// Results cannot be stalled: each is shown for exactly one cycle.
`include "huffman_tree_build_code_decode_defines.svh"

module huffman_tree_build_code_decode #(
   parameter int LEAVES = huf_pkg::LEAVES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_opcode,
   input  logic [huf_pkg::SYM_W-1:0]   req_symbol,
   input  logic [huf_pkg::WEIGHT_W-1:0] req_weight,
   input  logic                        req_bit_value,
   input  logic                        req_end_of_stream,
   output logic                        rsp_strobe,
   output logic                        rsp_result_kind,
   output logic [huf_pkg::SYM_W-1:0]   rsp_out_symbol,
   output logic [huf_pkg::LIDX_W-1:0]  rsp_leaf_index,
   output logic [huf_pkg::CODE_W-1:0]  rsp_code_bits,
   output logic [huf_pkg::CLEN_W-1:0]  rsp_code_length,
   output logic                        rsp_last
);

   localparam int NODES = 2 * LEAVES - 1;
   localparam int NW    = $clog2(NODES);
   localparam int LW    = $clog2(LEAVES);
   localparam int WW    = huf_pkg::WEIGHT_W + $clog2(LEAVES);
   localparam int SW    = huf_pkg::SYM_W;
   localparam int CW    = huf_pkg::CODE_W;
   localparam int XW    = huf_pkg::LIDX_W;
   localparam int QW    = huf_pkg::CLEN_W;
   localparam logic [NW-1:0] ROOT = NW'(NODES - 1);
   localparam logic [NW-1:0] LEAF_LIM = NW'(LEAVES);
   localparam logic [LW-1:0] LAST_LEAF = LW'(LEAVES - 1);

   // control state
   huf_pkg::state_type state_ff, state_in;
   logic [LW-1:0] cnt_ff, cnt_in;
   logic          ready_ff, ready_in;
   logic [NW-1:0] walk_ff, walk_in;
   logic          strobe_ff, strobe_in;

   // build / emit / decode working registers
   logic [NW-1:0] k_ff, k_in;
   logic [NW-1:0] scan_ff, scan_in;
   logic          pass_ff, pass_in;
   logic          svld_ff, svld_in;
   logic [NW-1:0] sidx_ff, sidx_in;
   logic [NW-1:0] a_ff, a_in;
   logic [WW-1:0] wa_ff, wa_in;
   logic [NW-1:0] b_ff, b_in;
   logic [WW-1:0] wb_ff, wb_in;
   logic [NODES-1:0] hp_ff, hp_in;   // node has a parent
   logic [LW-1:0] ei_ff, ei_in;
   logic [NW-1:0] c_ff, c_in;
   logic [NW-1:0] len_ff, len_in;
   logic [CW-1:0] bits_ff, bits_in;
   logic          dbit_ff, dbit_in;
   logic          deos_ff, deos_in;
   logic [LW-1:0] didx_ff, didx_in;

   // result registers
   logic          kind_ff, kind_in;
   logic [SW-1:0] osym_ff, osym_in;
   logic [XW-1:0] oidx_ff, oidx_in;
   logic [CW-1:0] obits_ff, obits_in;
   logic [QW-1:0] olen_ff, olen_in;
   logic          olast_ff, olast_in;

   // memories
   logic          w_we, w_re;
   logic [NW-1:0] w_waddr, w_raddr;
   logic [WW-1:0] w_wdata, w_rdata;
   logic          s_we, s_re;
   logic [LW-1:0] s_waddr, s_raddr;
   logic [SW-1:0] s_rdata;
   logic          p_we, p_re;
   logic [NW-1:0] p_waddr;
   logic [NW:0]   p_wdata, p_rdata;
   logic          lr_we, lr_re;
   logic [NW-1:0] l_rdata, r_rdata;

   huf_pkg::minsel_ctl_type ms_ctl;
   logic [NW-1:0] ms_idx;
   logic [WW-1:0] ms_w;

   logic [LW-1:0]    load_idx;
   logic [NW-1:0]    nxt;
   logic [LW+XW-1:0] ei_ext, didx_ext;
   logic [NW+QW-1:0] len_ext;
   logic             accept;

   assign accept   = start && (state_ff == huf_pkg::ST_IDLE);
   assign load_idx = ready_ff ? '0 : cnt_ff;
   assign nxt      = dbit_ff ? r_rdata : l_rdata;
   assign ei_ext   = {{XW{1'b0}}, ei_ff};
   assign didx_ext = {{XW{1'b0}}, didx_ff};
   assign len_ext  = {{QW{1'b0}}, len_ff};

   huf_ram #(.WIDTH(WW), .DEPTH(NODES)) u_weight_ram (
      .clock(clock), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
      .re(w_re), .raddr(w_raddr), .rdata(w_rdata)
   );

   huf_ram #(.WIDTH(SW), .DEPTH(LEAVES)) u_symbol_ram (
      .clock(clock), .we(s_we), .waddr(s_waddr), .wdata(req_symbol),
      .re(s_re), .raddr(s_raddr), .rdata(s_rdata)
   );

   // parent index with a right-child flag on top
   huf_ram #(.WIDTH(NW + 1), .DEPTH(NODES)) u_parent_ram (
      .clock(clock), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
      .re(p_re), .raddr(c_ff), .rdata(p_rdata)
   );

   huf_ram #(.WIDTH(NW), .DEPTH(NODES)) u_left_ram (
      .clock(clock), .we(lr_we), .waddr(k_ff), .wdata(a_ff),
      .re(lr_re), .raddr(walk_ff), .rdata(l_rdata)
   );

   huf_ram #(.WIDTH(NW), .DEPTH(NODES)) u_right_ram (
      .clock(clock), .we(lr_we), .waddr(k_ff), .wdata(b_ff),
      .re(lr_re), .raddr(walk_ff), .rdata(r_rdata)
   );

   // shared compare unit used by both scans of every merge
   huf_minsel #(.IW(NW), .WW(WW)) u_minsel (
      .clock(clock), .ctl(ms_ctl), .idx(sidx_ff), .weight(w_rdata),
      .best_idx(ms_idx), .best_w(ms_w)
   );

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      ready_in  = ready_ff;
      walk_in   = walk_ff;
      strobe_in = 1'b0;
      k_in      = k_ff;
      scan_in   = scan_ff;
      pass_in   = pass_ff;
      svld_in   = 1'b0;
      sidx_in   = sidx_ff;
      a_in      = a_ff;
      wa_in     = wa_ff;
      b_in      = b_ff;
      wb_in     = wb_ff;
      hp_in     = hp_ff;
      ei_in     = ei_ff;
      c_in      = c_ff;
      len_in    = len_ff;
      bits_in   = bits_ff;
      dbit_in   = dbit_ff;
      deos_in   = deos_ff;
      didx_in   = didx_ff;
      kind_in   = kind_ff;
      osym_in   = osym_ff;
      oidx_in   = oidx_ff;
      obits_in  = obits_ff;
      olen_in   = olen_ff;
      olast_in  = olast_ff;

      w_we    = 1'b0;
      w_waddr = k_ff;
      w_wdata = wa_ff + wb_ff;
      w_re    = 1'b0;
      w_raddr = scan_ff;
      s_we    = 1'b0;
      s_waddr = load_idx;
      s_re    = 1'b0;
      s_raddr = ei_ff;
      p_we    = 1'b0;
      p_waddr = a_ff;
      p_wdata = {1'b0, k_ff};
      p_re    = 1'b0;
      lr_we   = 1'b0;
      lr_re   = 1'b0;

      // a node is offered if it is parentless and not the first pick
      ms_ctl.clear  = 1'b0;
      ms_ctl.sample = svld_ff && !hp_ff[sidx_ff] && !(pass_ff && sidx_ff == a_ff);

      case (state_ff)
         huf_pkg::ST_IDLE: begin
            if (accept && req_opcode == huf_pkg::OP_LOAD) begin
               ready_in = 1'b0;
               s_we     = 1'b1;
               w_we     = 1'b1;
               w_waddr  = {{(NW-LW){1'b0}}, load_idx};
               w_wdata  = {{(WW-huf_pkg::WEIGHT_W){1'b0}}, req_weight};
               if (load_idx == LAST_LEAF) begin
                  ms_ctl.clear = 1'b1;   // min-select starts clean
                  cnt_in   = '0;
                  hp_in    = '0;
                  k_in     = LEAF_LIM;
                  scan_in  = '0;
                  pass_in  = 1'b0;
                  state_in = huf_pkg::ST_SCAN;
               end else begin
                  cnt_in = load_idx + LW'(1);
               end
            end else if (accept && ready_ff) begin
               lr_re    = 1'b1;
               dbit_in  = req_bit_value;
               deos_in  = req_end_of_stream;
               state_in = huf_pkg::ST_DEC_WAIT;
            end
         end
         huf_pkg::ST_SCAN: begin
            w_re    = 1'b1;
            svld_in = 1'b1;
            sidx_in = scan_ff;
            if (scan_ff == k_ff - NW'(1)) begin
               state_in = huf_pkg::ST_SCAN_END;
            end else begin
               scan_in = scan_ff + NW'(1);
            end
         end
         huf_pkg::ST_SCAN_END: begin
            state_in = huf_pkg::ST_SCAN_DONE;
         end
         huf_pkg::ST_SCAN_DONE: begin
            ms_ctl.clear = 1'b1;
            if (!pass_ff) begin
               a_in     = ms_idx;
               wa_in    = ms_w;
               pass_in  = 1'b1;
               scan_in  = '0;
               state_in = huf_pkg::ST_SCAN;
            end else begin
               b_in     = ms_idx;
               wb_in    = ms_w;
               state_in = huf_pkg::ST_MERGE_A;
            end
         end
         huf_pkg::ST_MERGE_A: begin
            w_we      = 1'b1;
            lr_we     = 1'b1;
            p_we      = 1'b1;
            hp_in[a_ff] = 1'b1;
            hp_in[b_ff] = 1'b1;
            state_in  = huf_pkg::ST_MERGE_B;
         end
         huf_pkg::ST_MERGE_B: begin
            p_we    = 1'b1;
            p_waddr = b_ff;
            p_wdata = {1'b1, k_ff};
            pass_in = 1'b0;
            scan_in = '0;
            if (k_ff == ROOT) begin
               ei_in    = '0;
               state_in = huf_pkg::ST_EMIT_START;
            end else begin
               k_in     = k_ff + NW'(1);
               state_in = huf_pkg::ST_SCAN;
            end
         end
         huf_pkg::ST_EMIT_START: begin
            s_re     = 1'b1;
            c_in     = {{(NW-LW){1'b0}}, ei_ff};
            len_in   = '0;
            bits_in  = '0;
            state_in = huf_pkg::ST_EMIT_CHK;
         end
         huf_pkg::ST_EMIT_CHK: begin
            if (hp_ff[c_ff]) begin
               p_re     = 1'b1;
               state_in = huf_pkg::ST_EMIT_WAIT;
            end else begin
               strobe_in = 1'b1;
               kind_in   = huf_pkg::KIND_CODE;
               osym_in   = s_rdata;
               oidx_in   = ei_ext[XW-1:0];
               obits_in  = bits_ff;
               olen_in   = len_ext[QW-1:0];
               olast_in  = (ei_ff == LAST_LEAF);
               if (ei_ff == LAST_LEAF) begin
                  ready_in = 1'b1;
                  walk_in  = ROOT;
                  state_in = huf_pkg::ST_IDLE;
               end else begin
                  ei_in    = ei_ff + LW'(1);
                  state_in = huf_pkg::ST_EMIT_START;
               end
            end
         end
         huf_pkg::ST_EMIT_WAIT: begin
            if (p_rdata[NW]) begin
               bits_in = bits_ff | (CW'(1) << len_ff);
            end
            len_in   = len_ff + NW'(1);
            c_in     = p_rdata[NW-1:0];
            state_in = huf_pkg::ST_EMIT_CHK;
         end
         huf_pkg::ST_DEC_WAIT: begin
            if (nxt < LEAF_LIM) begin
               s_re     = 1'b1;
               s_raddr  = nxt[LW-1:0];
               didx_in  = nxt[LW-1:0];
               walk_in  = ROOT;
               state_in = huf_pkg::ST_DEC_SYM;
            end else begin
               walk_in  = deos_ff ? ROOT : nxt;
               state_in = huf_pkg::ST_IDLE;
            end
         end
         huf_pkg::ST_DEC_SYM: begin
            strobe_in = 1'b1;
            kind_in   = huf_pkg::KIND_SYMBOL;
            osym_in   = s_rdata;
            oidx_in   = didx_ext[XW-1:0];
            obits_in  = '0;
            olen_in   = '0;
            olast_in  = 1'b0;
            state_in  = huf_pkg::ST_IDLE;
         end
         default: begin
            state_in = huf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= huf_pkg::ST_IDLE;
         cnt_ff    <= '0;
         ready_ff  <= 1'b0;
         walk_ff   <= ROOT;
         strobe_ff <= 1'b0;
         svld_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         ready_ff  <= ready_in;
         walk_ff   <= walk_in;
         strobe_ff <= strobe_in;
         svld_ff   <= svld_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff     <= k_in;
      scan_ff  <= scan_in;
      pass_ff  <= pass_in;
      sidx_ff  <= sidx_in;
      a_ff     <= a_in;
      wa_ff    <= wa_in;
      b_ff     <= b_in;
      wb_ff    <= wb_in;
      hp_ff    <= hp_in;
      ei_ff    <= ei_in;
      c_ff     <= c_in;
      len_ff   <= len_in;
      bits_ff  <= bits_in;
      dbit_ff  <= dbit_in;
      deos_ff  <= deos_in;
      didx_ff  <= didx_in;
      kind_ff  <= kind_in;
      osym_ff  <= osym_in;
      oidx_ff  <= oidx_in;
      obits_ff <= obits_in;
      olen_ff  <= olen_in;
      olast_ff <= olast_in;
   end

   assign busy            = (state_ff != huf_pkg::ST_IDLE);
   assign rsp_strobe      = strobe_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_out_symbol  = osym_ff;
   assign rsp_leaf_index  = oidx_ff;
   assign rsp_code_bits   = obits_ff;
   assign rsp_code_length = olen_ff;
   assign rsp_last        = olast_ff;

   // a decoded symbol only ever comes from a built tree
   `HUF_ASSERT_NOW(a_dec_needs_tree, rsp_strobe && rsp_result_kind == huf_pkg::KIND_SYMBOL, ready_ff, "decoded symbol without a built tree")
   // the last table entry closes the build
   `HUF_ASSERT_NOW(a_last_ends_build, rsp_strobe && rsp_last, !busy && ready_ff, "last code entry while build still running")
   // a decode before any build is dropped silently
   `HUF_ASSERT_NEXT(a_early_dec_dropped, start && !busy && req_opcode == huf_pkg::OP_DECODE && !ready_ff, !busy && !rsp_strobe, "decode before build was not ignored")

endmodule

/* hw/rtl/huf_ram.sv */
module huf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* hw/rtl/huf_minsel.sv */
// Running minimum over a stream of node weights; first seen wins ties.
module huf_minsel #(
   parameter int IW = 5,
   parameter int WW = 20
) (
   input  logic                    clock,
   input  huf_pkg::minsel_ctl_type ctl,
   input  logic [IW-1:0]           idx,
   input  logic [WW-1:0]           weight,
   output logic [IW-1:0]           best_idx,
   output logic [WW-1:0]           best_w
);

   logic          found_ff, found_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [WW-1:0] w_ff, w_in;

   always_comb begin
      found_in = found_ff;
      idx_in   = idx_ff;
      w_in     = w_ff;
      if (ctl.clear) begin
         found_in = 1'b0;
      end else if (ctl.sample && (!found_ff || weight < w_ff)) begin
         found_in = 1'b1;
         idx_in   = idx;
         w_in     = weight;
      end
   end

   always_ff @(posedge clock) begin
      found_ff <= found_in;
      idx_ff   <= idx_in;
      w_ff     <= w_in;
   end

   assign best_idx = idx_ff;
   assign best_w   = w_ff;

endmodule

/* tb/huffman_checker.sv */
module huffman_checker #(
   parameter int LEAVES = huf_pkg::LEAVES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  logic                         req_opcode,
   input  logic [huf_pkg::SYM_W-1:0]    req_symbol,
   input  logic [huf_pkg::WEIGHT_W-1:0] req_weight,
   input  logic                         req_bit_value,
   input  logic                         req_end_of_stream,
   input  logic                         rsp_strobe,
   input  logic                         rsp_result_kind,
   input  logic [huf_pkg::SYM_W-1:0]    rsp_out_symbol,
   input  logic [huf_pkg::LIDX_W-1:0]   rsp_leaf_index,
   input  logic [huf_pkg::CODE_W-1:0]   rsp_code_bits,
   input  logic [huf_pkg::CLEN_W-1:0]   rsp_code_length,
   input  logic                         rsp_last,
   output int                           fail_count,
   output int                           pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NODES = 2 * LEAVES - 1;
   localparam int WW    = huf_pkg::WEIGHT_W + $clog2(LEAVES);

   typedef struct packed {
      logic                       kind;
      logic [huf_pkg::SYM_W-1:0]  sym;
      logic [huf_pkg::LIDX_W-1:0] lidx;
      logic [huf_pkg::CODE_W-1:0] bits;
      logic [huf_pkg::CLEN_W-1:0] len;
      logic                       last;
   } huf_result_type;

   huf_result_type expected_q[$];

   logic [WW-1:0]             wt[NODES];
   int                        par[NODES];
   int                        lchild[NODES];
   int                        rchild[NODES];
   bit                        has_par[NODES];
   logic [huf_pkg::SYM_W-1:0] sym_store[LEAVES];
   int                        n_loaded;
   bit                        built;
   int                        walk;

   assign pending = expected_q.size();

   task automatic report(string what, int got, int want);
      $display("%0t: %s got %0h expected %0h", $time, what, got, want);
      fail_count++;
   endtask

   function automatic int lightest(int limit, int skip);
      int best_i;
      bit found;
      best_i = 0;
      found = 0;
      for (int i = 0; i < limit; i++)
         if (!has_par[i] && i != skip && (!found || wt[i] < wt[best_i])) begin
            best_i = i;
            found = 1;
         end
      return best_i;
   endfunction

   // merge pass, then one code entry per leaf walking up to the root
   task automatic build_and_list_codes();
      int a, b, c, len;
      logic [huf_pkg::CODE_W-1:0] bits;
      huf_result_type r;
      for (int k = 0; k < NODES; k++) has_par[k] = 0;
      for (int k = LEAVES; k < NODES; k++) begin
         a = lightest(k, NODES);
         b = lightest(k, a);
         par[a] = k;
         par[b] = k;
         has_par[a] = 1;
         has_par[b] = 1;
         lchild[k] = a;
         rchild[k] = b;
         wt[k] = wt[a] + wt[b];
      end
      for (int i = 0; i < LEAVES; i++) begin
         c = i;
         len = 0;
         bits = '0;
         while (has_par[c]) begin
            if (lchild[par[c]] != c && len < huf_pkg::CODE_W) bits[len] = 1'b1;
            len++;
            c = par[c];
         end
         r.kind = huf_pkg::KIND_CODE;
         r.sym  = sym_store[i];
         r.lidx = huf_pkg::LIDX_W'(i);
         r.bits = bits;
         r.len  = huf_pkg::CLEN_W'(len);
         r.last = (i == LEAVES - 1);
         expected_q.push_back(r);
      end
   endtask

   task automatic predict();
      huf_result_type r;
      if (req_opcode == huf_pkg::OP_LOAD) begin
         if (built) begin
            built = 0;
            n_loaded = 0;
         end
         sym_store[n_loaded] = req_symbol;
         wt[n_loaded] = WW'(req_weight);
         n_loaded++;
         if (n_loaded == LEAVES) begin
            build_and_list_codes();
            built = 1;
            n_loaded = 0;
            walk = NODES - 1;
         end
      end else if (built) begin
         walk = req_bit_value ? rchild[walk] : lchild[walk];
         if (walk < LEAVES) begin
            r = '0;
            r.kind = huf_pkg::KIND_SYMBOL;
            r.sym  = sym_store[walk];
            r.lidx = huf_pkg::LIDX_W'(walk);
            expected_q.push_back(r);
            walk = NODES - 1;
         end
         if (req_end_of_stream) walk = NODES - 1;
      end
   endtask

   task automatic compare();
      huf_result_type w;
      if (expected_q.size() == 0) begin
         report("unexpected result, kind", rsp_result_kind, 0);
         return;
      end
      w = expected_q.pop_front();
      if (rsp_result_kind !== w.kind) report("result_kind", rsp_result_kind, w.kind);
      if (rsp_out_symbol !== w.sym) report("out_symbol", rsp_out_symbol, w.sym);
      if (rsp_leaf_index !== w.lidx) report("leaf_index", rsp_leaf_index, w.lidx);
      if (rsp_code_bits !== w.bits) report("code_bits", rsp_code_bits, w.bits);
      if (rsp_code_length !== w.len) report("code_length", rsp_code_length, w.len);
      if (rsp_last !== w.last) report("last", rsp_last, w.last);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         n_loaded = 0;
         built = 0;
         walk = NODES - 1;
         fail_count = 0;
      end else begin
         if (rsp_strobe === 1'b1) compare();
         if (start && !busy) predict();
      end
   end

endmodule

/* tb/tb_huffman_tree_build_code_decode.sv */
module tb_huffman_tree_build_code_decode;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LEAVES    = huf_pkg::LEAVES_DEF;
   localparam int RUN_LIMIT = 400000;   // cycles; slowest run is far below

   logic                         clock;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic                         req_opcode;
   logic [huf_pkg::SYM_W-1:0]    req_symbol;
   logic [huf_pkg::WEIGHT_W-1:0] req_weight;
   logic                         req_bit_value;
   logic                         req_end_of_stream;
   logic                         rsp_strobe;
   logic                         rsp_result_kind;
   logic [huf_pkg::SYM_W-1:0]    rsp_out_symbol;
   logic [huf_pkg::LIDX_W-1:0]   rsp_leaf_index;
   logic [huf_pkg::CODE_W-1:0]   rsp_code_bits;
   logic [huf_pkg::CLEN_W-1:0]   rsp_code_length;
   logic                         rsp_last;
   int                           fail_count;
   int                           pending;
   int                           cycle_count;
   int                           sent;
   bit                           quiet_stretch;   // no idle gaps while set

   huffman_tree_build_code_decode #(.LEAVES(LEAVES)) dut (.*);

   huffman_checker #(.LEAVES(LEAVES)) u_checker (.*);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // one transfer: hold start until an edge with busy low; gaps ~16 percent
   task automatic issue(logic op, logic [huf_pkg::SYM_W-1:0] sym,
                        logic [huf_pkg::WEIGHT_W-1:0] w, logic b, logic eos);
      while (!quiet_stretch && $urandom_range(99) < 16) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start             <= 1'b1;
      req_opcode        <= op;
      req_symbol        <= sym;
      req_weight        <= w;
      req_bit_value     <= b;
      req_end_of_stream <= eos;
      do @(posedge clock); while (busy);
      sent++;
   endtask

   task automatic load_leaf(logic [huf_pkg::SYM_W-1:0] sym, logic [huf_pkg::WEIGHT_W-1:0] w);
      issue(huf_pkg::OP_LOAD, sym, w, 1'($urandom_range(1)), 1'($urandom_range(1)));
   endtask

   task automatic decode_bit(logic b, logic eos);
      issue(huf_pkg::OP_DECODE, huf_pkg::SYM_W'($urandom_range(255)),
            huf_pkg::WEIGHT_W'($urandom), b, eos);
   endtask

   // weight styles: 0 random, 1 tiny (many ties), 2 doubling (deep tree)
   task automatic load_set(int style);
      logic [huf_pkg::WEIGHT_W-1:0] w;
      for (int i = 0; i < LEAVES; i++) begin
         case (style)
            0: begin
               w = huf_pkg::WEIGHT_W'($urandom);
            end
            1: begin
               w = huf_pkg::WEIGHT_W'($urandom_range(3));
            end
            default: begin
               w = (i < 15) ? huf_pkg::WEIGHT_W'(1 << i) : 16'hFFFF;
            end
         endcase
         load_leaf(huf_pkg::SYM_W'($urandom_range(255)), w);
      end
   endtask

   initial begin
      int n;
      reset             <= 1'b1;
      start             <= 1'b0;
      req_opcode        <= huf_pkg::OP_LOAD;
      req_symbol        <= '0;
      req_weight        <= '0;
      req_bit_value     <= 1'b0;
      req_end_of_stream <= 1'b0;
      sent              = 0;
      quiet_stretch     = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: decodes before any tree are dropped
      decode_bit(1'b0, 1'b0);
      decode_bit(1'b1, 1'b1);
      // extremes: all-max weights, full-scale sums, symbols 00 and FF
      for (int i = 0; i < LEAVES; i++)
         load_leaf((i % 2) ? 8'hFF : 8'h00, 16'hFFFF);
      decode_bit(1'b0, 1'b0);
      decode_bit(1'b1, 1'b1);    // end of stream mid-walk
      decode_bit(1'b1, 1'b0);
      // a load after a build starts over; the decode below is dropped
      load_leaf(8'hA5, 16'h0000);
      decode_bit(1'b1, 1'b0);

      // random: mostly full sets then bit streams, some torn sets
      while (sent < 280) begin
         quiet_stretch = (sent >= 120 && sent < 200);
         if ($urandom_range(9) == 0) begin
            n = $urandom_range(1, LEAVES - 1);
            repeat (n) load_leaf(huf_pkg::SYM_W'($urandom_range(255)),
                                 huf_pkg::WEIGHT_W'($urandom));
         end
         load_set($urandom_range(2));
         n = $urandom_range(10, 40);
         repeat (n) decode_bit(1'($urandom_range(1)), $urandom_range(9) == 0);
      end
      start <= 1'b0;

      // drain, then let the block settle
      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
